// File: sv/npc_pkg.sv
// shared types and constants of the nearest peak classifier
package npc_pkg;

    localparam int PEAK_INDEX_W = 6;
    localparam int CRYSTAL_W    = 6;
    localparam int M_DATA_W     = ((CRYSTAL_W + 7) / 8) * 8;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic STATUS_MATCHED      = 1'b0;
    localparam logic STATUS_OUT_OF_RANGE = 1'b1;

    // control part of a word as it moves down the chain
    typedef struct packed {
        logic                    valid;
        logic                    classify;
        logic                    oor;
        logic [PEAK_INDEX_W-1:0] peak_index;
        logic [CRYSTAL_W-1:0]    best_k;
    } npc_ctl_t;

endpackage

// File: sv/npc_cell.sv
// one chain cell: holds one peak, loads it and scores passing events against it
module npc_cell import npc_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int DIST_WIDTH  = 33,
    parameter int CELL_INDEX  = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  npc_ctl_t                      ctl_in,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic [DIST_WIDTH-1:0]         d_in,
    output npc_ctl_t                      ctl_out,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic [DIST_WIDTH-1:0]         d_out
);

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int SUM_W = SQ_W + 1;
    localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'({64{1'b1}});

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;

    npc_ctl_t                      ctl1_reg;
    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg;
    logic [DIST_WIDTH-1:0]         d1_reg;
    logic [SQ_W-1:0]               sx_reg, sy_reg;

    npc_ctl_t                      ctl2_reg, ctl2_next;
    logic signed [COORD_WIDTH-1:0] x2_reg, y2_reg;
    logic [DIST_WIDTH-1:0]         d2_reg, d2_next;

    logic                          load_hit;
    logic signed [COORD_WIDTH:0]   diff_x, diff_y;
    logic [COORD_WIDTH-1:0]        mag_x, mag_y;
    logic [SQ_W-1:0]               sx_next, sy_next;
    logic [SUM_W-1:0]              sum, sum_sat;
    logic [DIST_WIDTH-1:0]         dist_sq;
    logic                          take;

    assign load_hit = ctl_in.valid && (ctl_in.classify == FUNC_LOAD)
                      && (32'(ctl_in.peak_index) == 32'(CELL_INDEX));

    // stage one: absolute differences and squares
    always_comb begin
        diff_x  = (COORD_WIDTH+1)'(px_reg) - (COORD_WIDTH+1)'(x_in);
        diff_y  = (COORD_WIDTH+1)'(py_reg) - (COORD_WIDTH+1)'(y_in);
        mag_x   = diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
        mag_y   = diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
        sx_next = mag_x * mag_x;
        sy_next = mag_y * mag_y;
    end

    // stage two: sum, clamp to 64 bits, keep the lower score
    always_comb begin
        sum     = SUM_W'(sx_reg) + SUM_W'(sy_reg);
        sum_sat = (sum > SAT_LIMIT) ? SAT_LIMIT : sum;
        dist_sq = DIST_WIDTH'(sum_sat);
        take    = ctl1_reg.valid && (ctl1_reg.classify == FUNC_CLASSIFY) && !ctl1_reg.oor
                  && ((CELL_INDEX == 0) || (dist_sq < d1_reg));
        ctl2_next = ctl1_reg;
        d2_next   = d1_reg;
        if (take) begin
            ctl2_next.best_k = CRYSTAL_W'(CELL_INDEX);
            d2_next          = dist_sq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && load_hit) begin
            px_reg <= x_in;
            py_reg <= y_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x_in;
            y1_reg <= y_in;
            d1_reg <= d_in;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            d2_reg <= d2_next;
        end
    end

    assign ctl_out = ctl2_reg;
    assign x_out   = x2_reg;
    assign y_out   = y2_reg;
    assign d_out   = d2_reg;

endmodule

// File: sv/nearest_peak_classifier.sv
// nearest peak classifier: a pipelined chain of peak cells
//
// input stream: s_axis_tuser picks the operation, 0 loads one peak table entry
// (index and position in s_axis_tdata), 1 classifies an event position.
// every word flows down a chain of NUM_PEAKS cells, each holding one peak and
// passing the word through two registers, so loads and classifies stay in order.
// a classify word gives one result word: crystal in m_axis_tdata, status in
// m_axis_tuser (1 when a coordinate magnitude is above 1.0, crystal then 0).
// a load word gives no result. all entries are to be loaded before classifying.
// from accept to result a word passes the input register, two registers per
// cell and the output register.
// throughput is one word per cycle while the receiver does not stall, set by
// the chain advancing one register stage per cycle.
// when the receiver stalls with a result pending, the whole chain holds and
// s_axis_tready drops until that result is taken.
// reset empties the chain and the output register; the peak table is not
// cleared.
module nearest_peak_classifier import npc_pkg::*; #(
    parameter int NUM_PEAKS   = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // peak_index, pos_x, pos_y, zero fill
    input  logic [((PEAK_INDEX_W+2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // crystal, zero fill
    output logic [M_DATA_W-1:0]                   m_axis_tdata,
    // status
    output logic                                  m_axis_tuser
);

    localparam int DIST_WIDTH = (2*COORD_WIDTH+1 > 64) ? 64 : 2*COORD_WIDTH+1;
    localparam logic signed [COORD_WIDTH-1:0] COORD_ONE =
        COORD_WIDTH'(1) <<< (COORD_WIDTH-2);

    logic                          en;
    logic signed [COORD_WIDTH-1:0] s_x, s_y;
    logic                          s_oor;

    npc_ctl_t                      in_ctl_reg, in_ctl_next;
    logic signed [COORD_WIDTH-1:0] in_x_reg, in_y_reg;

    npc_ctl_t                      ctl_w [NUM_PEAKS+1];
    logic signed [COORD_WIDTH-1:0] x_w   [NUM_PEAKS+1];
    logic signed [COORD_WIDTH-1:0] y_w   [NUM_PEAKS+1];
    logic [DIST_WIDTH-1:0]         d_w   [NUM_PEAKS+1];

    logic                          m_valid_reg, m_valid_next;
    logic [CRYSTAL_W-1:0]          crystal_reg;
    logic                          status_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign s_x   = s_axis_tdata[PEAK_INDEX_W +: COORD_WIDTH];
    assign s_y   = s_axis_tdata[PEAK_INDEX_W+COORD_WIDTH +: COORD_WIDTH];
    assign s_oor = (s_x > COORD_ONE) || (s_x < -COORD_ONE)
                   || (s_y > COORD_ONE) || (s_y < -COORD_ONE);

    always_comb begin
        in_ctl_next            = '0;
        in_ctl_next.valid      = s_axis_tvalid;
        in_ctl_next.classify   = (s_axis_tuser == FUNC_CLASSIFY);
        in_ctl_next.oor        = s_oor;
        in_ctl_next.peak_index = s_axis_tdata[PEAK_INDEX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg <= '0;
        end else if (en) begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_x_reg <= s_x;
            in_y_reg <= s_y;
        end
    end

    assign ctl_w[0] = in_ctl_reg;
    assign x_w[0]   = in_x_reg;
    assign y_w[0]   = in_y_reg;
    assign d_w[0]   = '0;

    for (genvar k = 0; k < NUM_PEAKS; k++) begin : g_cell
        npc_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .DIST_WIDTH  (DIST_WIDTH),
            .CELL_INDEX  (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_w[k]),
            .x_in    (x_w[k]),
            .y_in    (y_w[k]),
            .d_in    (d_w[k]),
            .ctl_out (ctl_w[k+1]),
            .x_out   (x_w[k+1]),
            .y_out   (y_w[k+1]),
            .d_out   (d_w[k+1])
        );
    end

    // positions and distance leaving the last cell are not needed
    logic unused_tail;
    assign unused_tail = ^{x_w[NUM_PEAKS], y_w[NUM_PEAKS], d_w[NUM_PEAKS]};

    assign m_valid_next = ctl_w[NUM_PEAKS].valid
                          && (ctl_w[NUM_PEAKS].classify == FUNC_CLASSIFY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            crystal_reg <= ctl_w[NUM_PEAKS].oor ? '0 : ctl_w[NUM_PEAKS].best_k;
            status_reg  <= ctl_w[NUM_PEAKS].oor ? STATUS_OUT_OF_RANGE : STATUS_MATCHED;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W-CRYSTAL_W){1'b0}}, crystal_reg};
    assign m_axis_tuser  = status_reg;

    a_oor_zero_crystal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == STATUS_OUT_OF_RANGE))
        |-> (m_axis_tdata[CRYSTAL_W-1:0] == '0 && !unused_tail || 1'b1)
            && (m_axis_tdata[CRYSTAL_W-1:0] == '0))
        else $error("out of range result with nonzero crystal");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_axis_tvalid && !in_ctl_reg.valid))
        else $error("chain not empty after reset");

    a_stall_holds_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(ctl_w[NUM_PEAKS])
            && $stable(in_ctl_reg)))
        else $error("chain moved during output stall");

    a_no_accept_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while chain holds");

endmodule

// File: bench/tb_nearest_peak_classifier.sv
// self-checking testbench of the nearest peak classifier
`timescale 1ns / 1ps

module tb_nearest_peak_classifier import npc_pkg::*;;

    localparam int NUM_PEAKS = 64;
    localparam int COORD_W   = 16;
    localparam int S_DATA_W  = ((PEAK_INDEX_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int X_LSB     = PEAK_INDEX_W;
    localparam int Y_LSB     = PEAK_INDEX_W + COORD_W;
    localparam int Q_ONE     = 1 << (COORD_W - 2);
    localparam int LATENCY   = 2 * NUM_PEAKS + 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        logic                    func;
        logic [PEAK_INDEX_W-1:0] idx;
        coord_t                  x;
        coord_t                  y;
        bit                      drain;   // hold back until no result is outstanding
    } word_t;

    typedef struct {
        logic [CRYSTAL_W-1:0] crystal;
        logic                 status;
    } verdict_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    nearest_peak_classifier #(
        .NUM_PEAKS   (NUM_PEAKS),
        .COORD_WIDTH (COORD_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    word_t    words_to_send[$];
    verdict_t verdicts_due[$];
    word_t    word_on_bus;
    coord_t   peak_x_tab [NUM_PEAKS];
    coord_t   peak_y_tab [NUM_PEAKS];
    int       n_offered  = 0;
    int       n_taken    = 0;
    int       n_errors   = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    bit       drain_next = 1'b0;
    bit       calm;

    // a stretch of the run with no random idling on either side
    assign calm = (n_taken >= 400) && (n_taken < 650);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("nearest_peak_classifier test failed");
        $finish;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // nearest peak by exact squared distance, lowest index kept on a tie
    function automatic verdict_t nearest_peak(input coord_t ex, input coord_t ey);
        verdict_t v;
        longint   dx;
        longint   dy;
        longint   dist_sq;
        longint   best;
        v.crystal = '0;
        v.status  = STATUS_MATCHED;
        best      = 0;
        if (ex > Q_ONE || ex < -Q_ONE || ey > Q_ONE || ey < -Q_ONE) begin
            v.status = STATUS_OUT_OF_RANGE;
            return v;
        end
        for (int k = 0; k < NUM_PEAKS; k++) begin
            dx      = longint'(peak_x_tab[k]) - longint'(ex);
            dy      = longint'(peak_y_tab[k]) - longint'(ey);
            dist_sq = dx * dx + dy * dy;
            if (k == 0 || dist_sq < best) begin
                best      = dist_sq;
                v.crystal = CRYSTAL_W'(k);
            end
        end
        return v;
    endfunction

    // sender side
    always @(negedge aclk) begin : drive_words
        logic nv;
        bit   gap;
        nv = s_axis_tvalid;
        if (aresetn && (!s_axis_tvalid || n_taken == n_offered)) begin
            gap = !calm && ($urandom_range(99) < 38);
            nv  = 1'b0;
            if (words_to_send.size() > 0 && !gap &&
                !(words_to_send[0].drain && verdicts_due.size() > 0)) begin
                word_on_bus = words_to_send.pop_front();
                n_offered++;
                nv = 1'b1;
                s_axis_tdata <= {{(S_DATA_W - Y_LSB - COORD_W){1'b0}},
                                 word_on_bus.y, word_on_bus.x, word_on_bus.idx};
                s_axis_tuser <= word_on_bus.func;
            end
        end
        s_axis_tvalid <= nv;
    end

    // receiver side, with one long hold-off so the chain backs up
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && n_taken >= 100) begin
            hold_done = 1'b1;
            hold_left = 500;
            rdy       = 1'b0;
        end else begin
            rdy = calm || ($urandom_range(99) >= 38);
        end
        m_axis_tready <= rdy;
    end

    always @(posedge aclk) begin : watch
        verdict_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    note_mismatch($sformatf("result with none pending: tdata %h tuser %b",
                                            m_axis_tdata, m_axis_tuser));
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata !== {{(M_DATA_W - CRYSTAL_W){1'b0}}, want.crystal})
                        note_mismatch($sformatf("crystal: got tdata %h, want %0d",
                                                m_axis_tdata, want.crystal));
                    if (m_axis_tuser !== want.status)
                        note_mismatch($sformatf("status: got %b, want %b",
                                                m_axis_tuser, want.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (word_on_bus.func == FUNC_LOAD) begin
                    peak_x_tab[word_on_bus.idx] = word_on_bus.x;
                    peak_y_tab[word_on_bus.idx] = word_on_bus.y;
                end else begin
                    verdicts_due.push_back(nearest_peak(word_on_bus.x, word_on_bus.y));
                end
                n_taken++;
            end
        end
    end

    // stimulus plan, with a shadow of the table to aim events at peaks
    coord_t plan_x [NUM_PEAKS];
    coord_t plan_y [NUM_PEAKS];

    task automatic queue_word(input logic func, input int idx, input int x, input int y);
        word_t w;
        w.func  = func;
        w.idx   = PEAK_INDEX_W'(idx);
        w.x     = coord_t'(x);
        w.y     = coord_t'(y);
        w.drain = drain_next;
        drain_next = 1'b0;
        if (func == FUNC_LOAD) begin
            plan_x[w.idx] = w.x;
            plan_y[w.idx] = w.y;
        end
        words_to_send.push_back(w);
    endtask

    task automatic queue_load(input int idx, input int x, input int y);
        queue_word(FUNC_LOAD, idx, x, y);
    endtask

    task automatic queue_event(input int x, input int y);
        queue_word(FUNC_CLASSIFY, $urandom_range(NUM_PEAKS - 1), x, y);
    endtask

    function automatic int clip(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int any_coord();
        return int'(coord_t'($urandom));
    endfunction

    function automatic int in_range_coord();
        return int'($urandom_range(2 * Q_ONE)) - Q_ONE;
    endfunction

    initial begin : stimulus
        int cx;
        int cy;
        int jit;
        int sel;
        int pick;
        int few_x [4];
        int few_y [4];

        // 8x8 grid spaced 0.25 apart, every entry written before any event
        for (int k = 0; k < NUM_PEAKS; k++)
            queue_load(k, -14336 + (k % 8) * 4096, -14336 + (k / 8) * 4096);

        // directed: duplicates, extreme peaks, ties and the range boundary
        queue_load(63, 6144, -14336);
        queue_load(62, -32768, 32767);
        queue_load(61, 32767, -32768);
        queue_load(60, Q_ONE, Q_ONE);
        queue_event(6144, -14336);           // duplicate peak, lower index wins
        queue_event(-12288, -14336);         // midway between two peaks
        queue_event(-12288, -12288);         // four-way tie
        queue_event(0, 0);
        queue_event(Q_ONE, Q_ONE);           // magnitude exactly one is in range
        queue_event(-Q_ONE, -Q_ONE);
        queue_event(Q_ONE, -Q_ONE);
        queue_event(-Q_ONE, Q_ONE);
        queue_event(Q_ONE + 1, 0);
        queue_event(-Q_ONE - 1, 0);
        queue_event(0, Q_ONE + 1);
        queue_event(0, -Q_ONE - 1);
        queue_event(Q_ONE, -Q_ONE - 1);
        queue_event(32767, 32767);
        queue_event(-32768, -32768);
        queue_event(-32768, 0);
        queue_event(1, -1);

        // random phases, each with a fresh table layout
        for (int ph = 0; ph < 5; ph++) begin
            drain_next = 1'b1;
            cx = in_range_coord();
            cy = in_range_coord();
            for (int j = 0; j < 4; j++) begin
                few_x[j] = in_range_coord();
                few_y[j] = in_range_coord();
            end
            for (int k = 0; k < NUM_PEAKS; k++) begin
                case (ph % 4)
                    0: begin
                        queue_load(k, -14336 + (k % 8) * 4096 + $urandom_range(1024) - 512,
                                   -14336 + (k / 8) * 4096 + $urandom_range(1024) - 512);
                    end
                    1: queue_load(k, any_coord(), any_coord());
                    2: begin
                        queue_load(k, clip(cx + int'($urandom_range(600)) - 300),
                                   clip(cy + int'($urandom_range(600)) - 300));
                    end
                    default: begin
                        pick = $urandom_range(3);
                        queue_load(k, few_x[pick], few_y[pick]);
                    end
                endcase
            end
            repeat (150) begin
                sel = $urandom_range(99);
                if (sel < 12) begin
                    queue_load($urandom_range(NUM_PEAKS - 1), any_coord(), any_coord());
                end else if (sel < 72) begin
                    // aim near a peak, small jitter gives near-ties
                    pick = $urandom_range(NUM_PEAKS - 1);
                    case ($urandom_range(2))
                        0:       jit = 4;
                        1:       jit = 64;
                        default: jit = 2048;
                    endcase
                    queue_event(clip(int'(plan_x[pick]) + int'($urandom_range(2 * jit)) - jit),
                                clip(int'(plan_y[pick]) + int'($urandom_range(2 * jit)) - jit));
                end else if (sel < 90) begin
                    queue_event(in_range_coord(), in_range_coord());
                end else begin
                    queue_event(any_coord(), any_coord());
                end
            end
        end

        while (words_to_send.size() > 0 || n_taken != n_offered || verdicts_due.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (n_errors == 0)
            $display("nearest_peak_classifier test passed");
        else
            $display("nearest_peak_classifier test failed");
        $finish;
    end

    initial begin : reset_seq
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

endmodule

// File: nearest_peak_classifier.f
sv/npc_pkg.sv
sv/npc_cell.sv
sv/nearest_peak_classifier.sv
bench/tb_nearest_peak_classifier.sv
